### rtl/core/c3f_pkg.sv
package c3f_pkg;

    // Default build parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int COEFF_BITS_DEF = 8;

    // Fixed field widths
    localparam int IMG_W_BITS     = 11;
    localparam int IMG_H_BITS     = 12;
    localparam int COEFF_ROW_BITS = 24;
    localparam int FILT_BITS      = 20;
    localparam int ROW_BITS       = 12;
    localparam int COL_OUT_BITS   = 10;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 24;

    // Configuration register map
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COEFF_TOP    = 3'd2,
        REG_COEFF_MID    = 3'd3,
        REG_COEFF_BOT    = 3'd4
    } cfg_reg_t;

    // Register reset values (identity kernel, 1024x1024 frame)
    localparam logic [IMG_W_BITS-1:0]     WIDTH_RST     = 11'd1024;
    localparam logic [IMG_H_BITS-1:0]     HEIGHT_RST    = 12'd1024;
    localparam logic [COEFF_ROW_BITS-1:0] COEFF_TOP_RST = 24'd0;
    localparam logic [COEFF_ROW_BITS-1:0] COEFF_MID_RST = 24'd256;
    localparam logic [COEFF_ROW_BITS-1:0] COEFF_BOT_RST = 24'd0;

    // Position tag that rides along with each result
    typedef struct packed {
        logic [ROW_BITS-1:0]     row;
        logic [COL_OUT_BITS-1:0] col;
        logic                    last;
    } result_tag_t;

endpackage

### rtl/core/conv3x3_interior_filter_top.sv
// A pixel passes the stage 1, window, product and output registers.
// Throughput: one pixel per cycle unless out_stall holds the pipeline; the
// line stores are read at accept and rewritten at that column on stage 1 exit.
// Only interior positions produce a result; border pixels produce none.
// Reset (rst_n, async, active low): counters, window and pipeline cleared,
// registers at reset values; line stores are not cleared, no init pass.
module conv3x3_interior_filter_top #(
    parameter int MAX_WIDTH  = c3f_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = c3f_pkg::PIXEL_BITS_DEF,
    parameter int COEFF_BITS = c3f_pkg::COEFF_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // pixel input
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [PIXEL_BITS-1:0]                   pixel,
    // result output
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [c3f_pkg::FILT_BITS-1:0]    filtered,
    output logic [c3f_pkg::ROW_BITS-1:0]            out_row,
    output logic [c3f_pkg::COL_OUT_BITS-1:0]        out_col,
    output logic                                    frame_last,
    // configuration writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [c3f_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [c3f_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

    import c3f_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int XW      = (IMG_W_BITS > COL_W + 1) ? IMG_W_BITS : COL_W + 1;
    localparam int PROD_W  = PIXEL_BITS + COEFF_BITS + 1;
    localparam int SUM_W   = PROD_W + 4;
    localparam int ACC_W   = (SUM_W > FILT_BITS) ? SUM_W : FILT_BITS;
    localparam int CROW_W  = 3 * COEFF_BITS;

    // Configuration registers
    logic [IMG_W_BITS-1:0]     image_width_reg;
    logic [IMG_H_BITS-1:0]     image_height_reg;
    logic [COEFF_ROW_BITS-1:0] coeff_row_reg [3];

    // Position counters
    logic [COL_W-1:0]    col_cnt_reg;
    logic [ROW_BITS-1:0] row_cnt_reg;

    // Geometry decode
    logic [XW-1:0]         width_x;
    logic [XW-1:0]         width_eff;
    logic [XW-1:0]         last_col;
    logic [IMG_H_BITS-1:0] height_eff;
    logic [IMG_H_BITS-1:0] last_row;
    logic                  end_col;
    logic                  end_row;
    logic                  emit;
    result_tag_t           tag_next;

    // Pipeline handshake
    logic in_accept;
    logic s1_ready;
    logic s1_adv;
    logic s2_ready;
    logic s3_ready;
    logic out_ready;

    // Stage 1: pixel waiting for line-store read data
    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic                  s1_emit_reg;
    result_tag_t           s1_tag_reg;

    logic [PIXEL_BITS-1:0] line_a_rd;
    logic [PIXEL_BITS-1:0] line_b_rd;

    // Stage 2: window
    logic [PIXEL_BITS-1:0] win_reg [3][3];
    logic                  s2_valid_reg;
    result_tag_t           s2_tag_reg;

    // Stage 3: products
    logic [CROW_W-1:0]         coeff_vec [3];
    logic signed [COEFF_BITS-1:0] coeff [3][3];
    logic signed [PROD_W-1:0]  prod_next [3][3];
    logic signed [PROD_W-1:0]  prod_reg [3][3];
    logic                      s3_valid_reg;
    result_tag_t               s3_tag_reg;
    logic signed [ACC_W-1:0]   acc;

    assign cfg_ready = 1'b1;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
            coeff_row_reg[0] <= COEFF_TOP_RST;
            coeff_row_reg[1] <= COEFF_MID_RST;
            coeff_row_reg[2] <= COEFF_BOT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_H_BITS-1:0];
                REG_COEFF_TOP:    coeff_row_reg[0] <= cfg_data[COEFF_ROW_BITS-1:0];
                REG_COEFF_MID:    coeff_row_reg[1] <= cfg_data[COEFF_ROW_BITS-1:0];
                REG_COEFF_BOT:    coeff_row_reg[2] <= cfg_data[COEFF_ROW_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp geometry and decode end of row / frame, interior test
    always_comb
    begin
        width_x = XW'(image_width_reg);
        if (width_x < XW'(3))
            width_eff = XW'(3);
        else if (width_x > XW'(MAX_WIDTH))
            width_eff = XW'(MAX_WIDTH);
        else
            width_eff = width_x;
        last_col = width_eff - XW'(1);

        if (image_height_reg < IMG_H_BITS'(3))
            height_eff = IMG_H_BITS'(3);
        else
            height_eff = image_height_reg;
        last_row = height_eff - IMG_H_BITS'(1);

        end_col = (XW'(col_cnt_reg) >= last_col);
        end_row = (row_cnt_reg >= last_row);
        emit    = (row_cnt_reg >= ROW_BITS'(2)) && (col_cnt_reg >= COL_W'(2));

        tag_next.row  = row_cnt_reg - ROW_BITS'(1);
        tag_next.col  = COL_OUT_BITS'(col_cnt_reg - COL_W'(1));
        tag_next.last = end_col && end_row;
    end

    // Ready chain from the output register back to the input
    assign out_ready = !out_valid || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign in_stall  = !s1_ready;
    assign in_accept = in_valid && s1_ready;

    // Column / row counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (in_accept)
        begin
            if (end_col)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= end_row ? '0 : row_cnt_reg + ROW_BITS'(1);
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + COL_W'(1);
            end
        end
    end

    // Stage 1 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg  <= pixel;
            s1_col_reg  <= col_cnt_reg;
            s1_emit_reg <= emit;
            s1_tag_reg  <= tag_next;
        end
    end

    // Line stores: read at accept, write back when the item leaves stage 1
    c3f_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (in_accept),
        .raddr (col_cnt_reg),
        .rdata (line_a_rd)
    );

    c3f_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (line_a_rd),
        .re    (in_accept),
        .raddr (col_cnt_reg),
        .rdata (line_b_rd)
    );

    // Window shift; every pixel shifts it, only interior ones go on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int m = 0; m < 3; m++)
            begin
                for (int n = 0; n < 3; n++)
                begin
                    win_reg[m][n] <= '0;
                end
            end
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            end
            if (s1_adv)
            begin
                for (int m = 0; m < 3; m++)
                begin
                    win_reg[m][0] <= win_reg[m][1];
                    win_reg[m][1] <= win_reg[m][2];
                end
                win_reg[0][2] <= line_b_rd;
                win_reg[1][2] <= line_a_rd;
                win_reg[2][2] <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_tag_reg <= s1_tag_reg;
        end
    end

    // Weight unpack and nine products
    always_comb
    begin
        for (int m = 0; m < 3; m++)
        begin
            coeff_vec[m] = CROW_W'(coeff_row_reg[m]);
            for (int n = 0; n < 3; n++)
            begin
                coeff[m][n]     = coeff_vec[m][n*COEFF_BITS +: COEFF_BITS];
                prod_next[m][n] = $signed({1'b0, win_reg[m][n]}) * coeff[m][n];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ready)
        begin
            prod_reg   <= prod_next;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    // Sum of products
    always_comb
    begin
        acc = '0;
        for (int m = 0; m < 3; m++)
        begin
            for (int n = 0; n < 3; n++)
            begin
                acc = acc + ACC_W'(prod_reg[m][n]);
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && out_ready)
        begin
            filtered   <= acc[FILT_BITS-1:0];
            out_row    <= s3_tag_reg.row;
            out_col    <= s3_tag_reg.col;
            frame_last <= s3_tag_reg.last;
        end
    end

endmodule

### rtl/core/c3f_ram.sv
module c3f_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### bench/conv3x3_interior_filter_top_tb.sv
module conv3x3_interior_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c3f_pkg::*;

    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int PW           = PIXEL_BITS_DEF;
    localparam int CW           = COEFF_BITS_DEF;
    localparam int MIN_DIM      = 3;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 30;
    localparam int RANDOM_ITEMS = 500;
    localparam int CALM_FROM    = 150;
    localparam int CALM_TO      = 350;
    localparam int SCAN_LIMIT   = 5000;
    localparam int IDX_UNUSED   = int'(REG_COEFF_BOT) + 1;
    localparam int IDX_LAST     = (1 << CFG_IDX_BITS) - 1;
    localparam int WIDTH_TOP    = (1 << IMG_W_BITS) - 1;
    localparam int HEIGHT_TOP   = (1 << IMG_H_BITS) - 1;
    localparam logic [COEFF_ROW_BITS-1:0] KERN_MIN = 24'h808080;
    localparam logic [COEFF_ROW_BITS-1:0] KERN_MAX = 24'h7F7F7F;

    // One interior result: weighted sum plus its position tag
    typedef struct packed {
        logic [FILT_BITS-1:0]    sum;
        logic [ROW_BITS-1:0]     row;
        logic [COL_OUT_BITS-1:0] col;
        logic                    last;
    } window_result_t;

    // Line-buffer convolution predictor and the queue of sums still due
    class interior_sum_board;
        logic [IMG_W_BITS-1:0]     width_reg;
        logic [IMG_H_BITS-1:0]     height_reg;
        logic [COEFF_ROW_BITS-1:0] coeff_top;
        logic [COEFF_ROW_BITS-1:0] coeff_mid;
        logic [COEFF_ROW_BITS-1:0] coeff_bot;
        logic [PW-1:0]             prev_row [MAX_W];
        logic [PW-1:0]             older_row [MAX_W];
        logic [PW-1:0]             win [3][3];
        int                        col_cnt;
        int                        row_cnt;
        window_result_t            sums_due [$];
        int                        errors;

        function new();
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            coeff_top  = COEFF_TOP_RST;
            coeff_mid  = COEFF_MID_RST;
            coeff_bot  = COEFF_BOT_RST;
            foreach (prev_row[i])
            begin
                prev_row[i]  = '0;
                older_row[i] = '0;
            end
            foreach (win[m, n])
                win[m][n] = '0;
            col_cnt = 0;
            row_cnt = 0;
            errors  = 0;
        endfunction

        function int eff_width();
            if (width_reg < MIN_DIM)
                return MIN_DIM;
            if (width_reg > MAX_W)
                return MAX_W;
            return int'(width_reg);
        endfunction

        function int eff_height();
            if (height_reg < MIN_DIM)
                return MIN_DIM;
            return int'(height_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = data[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg = data[IMG_H_BITS-1:0];
                REG_COEFF_TOP:    coeff_top  = data[COEFF_ROW_BITS-1:0];
                REG_COEFF_MID:    coeff_mid  = data[COEFF_ROW_BITS-1:0];
                REG_COEFF_BOT:    coeff_bot  = data[COEFF_ROW_BITS-1:0];
                default:          ;
            endcase
        endfunction

        // pixels left until both counters wrap back to the frame start
        function int pixels_to_frame_end();
            int c;
            int r;
            int w;
            int h;
            int cnt;
            c   = col_cnt;
            r   = row_cnt;
            w   = eff_width();
            h   = eff_height();
            cnt = 0;
            do
            begin
                cnt++;
                if (c >= w - 1)
                begin
                    c = 0;
                    r = (r >= h - 1) ? 0 : r + 1;
                end
                else
                    c++;
            end
            while ((c != 0 || r != 0) && cnt < SCAN_LIMIT);
            return cnt;
        endfunction

        function void note_pixel(logic [PW-1:0] pix);
            int                        w;
            int                        h;
            int                        sum;
            bit                        end_col;
            bit                        end_row;
            logic [COEFF_ROW_BITS-1:0] kern [3];
            window_result_t            res;
            w       = eff_width();
            h       = eff_height();
            end_col = (col_cnt >= w - 1);
            end_row = (row_cnt >= h - 1);

            // slide the window, new column comes from the line stores
            for (int m = 0; m < 3; m++)
            begin
                win[m][0] = win[m][1];
                win[m][1] = win[m][2];
            end
            win[0][2] = older_row[col_cnt];
            win[1][2] = prev_row[col_cnt];
            win[2][2] = pix;
            older_row[col_cnt] = prev_row[col_cnt];
            prev_row[col_cnt]  = pix;

            // interior position: full neighborhood present
            if (row_cnt >= 2 && col_cnt >= 2)
            begin
                kern[0] = coeff_top;
                kern[1] = coeff_mid;
                kern[2] = coeff_bot;
                sum = 0;
                for (int m = 0; m < 3; m++)
                    for (int n = 0; n < 3; n++)
                        sum += int'(win[m][n]) * int'($signed(kern[m][CW*n +: CW]));
                res.sum  = sum[FILT_BITS-1:0];
                res.row  = ROW_BITS'(row_cnt - 1);
                res.col  = COL_OUT_BITS'(col_cnt - 1);
                res.last = end_col && end_row;
                sums_due.push_back(res);
            end

            if (end_col)
            begin
                col_cnt = 0;
                row_cnt = end_row ? 0 : row_cnt + 1;
            end
            else
                col_cnt++;
        endfunction

        function void check_result(logic [FILT_BITS-1:0] sum, logic [ROW_BITS-1:0] row,
                                   logic [COL_OUT_BITS-1:0] col, logic last);
            window_result_t due;
            if (sums_due.size() == 0)
            begin
                $error("result with none due: filtered %0d row %0d col %0d",
                       $signed(sum), row, col);
                errors++;
                return;
            end
            due = sums_due.pop_front();
            if (sum !== due.sum)
            begin
                $error("filtered: expected %0d, got %0d", $signed(due.sum), $signed(sum));
                errors++;
            end
            if (row !== due.row)
            begin
                $error("out_row: expected %0d, got %0d", due.row, row);
                errors++;
            end
            if (col !== due.col)
            begin
                $error("out_col: expected %0d, got %0d", due.col, col);
                errors++;
            end
            if (last !== due.last)
            begin
                $error("frame_last: expected %0b, got %0b", due.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    logic [PW-1:0]                    pixel     = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic signed [FILT_BITS-1:0]      filtered;
    logic [ROW_BITS-1:0]              out_row;
    logic [COL_OUT_BITS-1:0]          out_col;
    logic                             frame_last;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [CFG_IDX_BITS-1:0]          cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]         cfg_data  = '0;

    interior_sum_board sb = new();
    bit                calm = 1'b0;
    int                random_items = 0;

    conv3x3_interior_filter_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .filtered   (filtered),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // random back-pressure on results
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

    // watch all three handshakes
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_pixel(pixel);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(filtered, out_row, out_col, frame_last);
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
    end

    // one pixel item, with random gaps ahead of it; valid stays up afterwards
    task automatic send_pixel(input logic [PW-1:0] p);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= p;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // valid stays up for back-to-back writes; caller lowers it
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // all due sums back, then let border pixels clear the pipeline
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.sums_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int sel;
        int wv;
        int hv;
        int togo;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame, most negative kernel, brightest pixels; junk index ignored
        write_reg(REG_IMAGE_WIDTH, MIN_DIM);
        write_reg(REG_IMAGE_HEIGHT, MIN_DIM);
        write_reg(REG_COEFF_TOP, KERN_MIN);
        write_reg(REG_COEFF_MID, KERN_MIN);
        write_reg(REG_COEFF_BOT, KERN_MIN);
        write_reg(IDX_LAST, '1);
        cfg_valid <= 1'b0;
        repeat (9) send_pixel('1);
        wait_idle();

        // most positive kernel
        write_reg(REG_COEFF_TOP, KERN_MAX);
        write_reg(REG_COEFF_MID, KERN_MAX);
        write_reg(REG_COEFF_BOT, KERN_MAX);
        cfg_valid <= 1'b0;
        repeat (9) send_pixel('1);
        wait_idle();

        // width and height below the minimum, mixed weights, 0/full pixels
        write_reg(REG_IMAGE_WIDTH, MIN_DIM - 2);
        write_reg(REG_IMAGE_HEIGHT, 0);
        write_reg(REG_COEFF_TOP, 24'h01FF80);
        write_reg(REG_COEFF_MID, 24'h7F0002);
        write_reg(REG_COEFF_BOT, 24'h80FE01);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? '1 : '0);
        wait_idle();

        // widest row: oversize width clamps to the line store depth;
        // one full row and the start of the next, the frame goes on below
        write_reg(REG_IMAGE_WIDTH, WIDTH_TOP);
        write_reg(REG_IMAGE_HEIGHT, MIN_DIM);
        write_reg(REG_COEFF_TOP, CFG_DATA_BITS'($urandom));
        write_reg(REG_COEFF_MID, CFG_DATA_BITS'($urandom));
        write_reg(REG_COEFF_BOT, CFG_DATA_BITS'($urandom));
        cfg_valid <= 1'b0;
        togo = MAX_W + MIN_DIM;
        repeat (togo) send_pixel(PW'($urandom));
        wait_idle();

        // random phases: new settings while idle, then mostly whole frames
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(1))
            begin
                sel = $urandom_range(99);
                // a wider row is only safe once the line stores start a fresh frame
                if (sb.col_cnt == 0 && sb.row_cnt == 0)
                begin
                    if (sel < 2)
                        wv = MAX_W;
                    else if (sel < 5)
                        wv = $urandom_range(WIDTH_TOP, MAX_W);
                    else if (sel < 12)
                        wv = $urandom_range(MIN_DIM - 1);
                    else
                        wv = $urandom_range(24, MIN_DIM);
                end
                else
                    wv = $urandom_range(sb.eff_width());
                write_reg(REG_IMAGE_WIDTH, wv);
            end
            if ($urandom_range(1))
            begin
                sel = $urandom_range(99);
                if (sel < 4)
                    hv = HEIGHT_TOP;
                else if (sel < 12)
                    hv = $urandom_range(MIN_DIM - 1);
                else
                    hv = $urandom_range(10, MIN_DIM);
                write_reg(REG_IMAGE_HEIGHT, hv);
            end
            if ($urandom_range(1))
                write_reg(REG_COEFF_TOP, ($urandom_range(9) == 0) ? KERN_MIN
                                                                  : CFG_DATA_BITS'($urandom));
            if ($urandom_range(1))
                write_reg(REG_COEFF_MID, ($urandom_range(9) == 0) ? KERN_MAX
                                                                  : CFG_DATA_BITS'($urandom));
            if ($urandom_range(1))
                write_reg(REG_COEFF_BOT, CFG_DATA_BITS'($urandom));
            if ($urandom_range(9) == 0)
                write_reg(CFG_IDX_BITS'($urandom_range(IDX_LAST, IDX_UNUSED)),
                          CFG_DATA_BITS'($urandom));
            cfg_valid <= 1'b0;

            togo = sb.pixels_to_frame_end();
            if (togo > 400 || $urandom_range(3) == 0)
                togo = $urandom_range(60, 1);
            repeat (togo)
            begin
                calm = (random_items >= CALM_FROM && random_items < CALM_TO);
                send_pixel(PW'($urandom));
                random_items++;
            end
            calm = 1'b0;
            wait_idle();
        end

        if (sb.errors == 0 && sb.sums_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/core/c3f_pkg.sv
rtl/core/c3f_ram.sv
rtl/core/conv3x3_interior_filter_top.sv
bench/conv3x3_interior_filter_top_tb.sv
